>>> src/mtfl_pkg.sv
// Shared constants, codes and types for the move-to-front list.
package mtfl_pkg;

	localparam int DEPTH  = 16;
	localparam int ITEM_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_APPEND   = 3'd1,
		CMD_DELETE   = 3'd2,
		CMD_TO_FRONT = 3'd3,
		CMD_CLEAR    = 3'd4,
		CMD_LOOKUP   = 3'd5,
		CMD_READ     = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NOTFOUND = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_RANGE    = 3'd4
	} stat_t;

	// What the row of cells does on the execute edge.
	typedef enum logic [2:0] {
		CC_NONE,
		CC_PUSH,
		CC_APPEND,
		CC_REMOVE,
		CC_TO_FRONT
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [IDX_W-1:0]  pos;
		logic [CNT_W-1:0]  count;
		logic [ITEM_W-1:0] item;
	} cell_ctl_t;

endpackage

>>> src/mtfl_cell.sv
// One list slot: holds an entry, compares it, and shifts with its neighbors.
module mtfl_cell (
	input  logic                          clk,
	input  logic [mtfl_pkg::IDX_W-1:0]    cell_idx,
	input  mtfl_pkg::cell_ctl_t           ctl,
	input  logic [mtfl_pkg::ITEM_W-1:0]   left_data,
	input  logic [mtfl_pkg::ITEM_W-1:0]   right_data,
	output logic [mtfl_pkg::ITEM_W-1:0]   data,
	output logic                          match
);

	logic [mtfl_pkg::ITEM_W-1:0] data_q;
	logic                        valid;

	assign valid = {1'b0, cell_idx} < ctl.count;
	assign match = valid && (data_q == ctl.item);
	assign data  = data_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			mtfl_pkg::CC_PUSH: begin
				data_q <= (cell_idx == '0) ? ctl.item : left_data;
			end
			mtfl_pkg::CC_APPEND: begin
				if ({1'b0, cell_idx} == ctl.count)
					data_q <= ctl.item;
			end
			mtfl_pkg::CC_REMOVE: begin
				if (cell_idx >= ctl.pos)
					data_q <= right_data;
			end
			mtfl_pkg::CC_TO_FRONT: begin
				if (cell_idx == '0)
					data_q <= ctl.item;
				else if (cell_idx <= ctl.pos)
					data_q <= left_data;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/move_to_front_ordered_list.sv
// Top level of the move-to-front ordered list: control, cell row and result register.
//
// Ordered list of up to 16 entries of 32 bits, duplicates allowed, head at
// position 0. A request is taken when start is high and busy is low. The
// accepting edge registers each request (busy goes high), and on the next
// edge all cells compare their entry against the item at once, a priority
// encoder picks the first match, and the row shifts or writes as the
// command needs in that same edge. The result sits on status, found, position,
// list_length and item_out for exactly one cycle with done high, the cycle
// after execution; busy is already low then, so the next request can be
// taken while done is shown. The receiver cannot stall done; it must take
// the result in that cycle. Reset clears the length, the state and done;
// entry contents are not cleared and need no clearing pass, since only
// entries below the length are ever read or matched.
module move_to_front_ordered_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  command,
	input  logic [31:0]                 item_value,
	input  logic [3:0]                  index,
	output logic                        done,
	output logic [2:0]                  status,
	output logic                        found,
	output logic [3:0]                  position,
	output logic [4:0]                  list_length,
	output logic [31:0]                 item_out
);

	localparam int DEPTH  = mtfl_pkg::DEPTH;
	localparam int ITEM_W = mtfl_pkg::ITEM_W;
	localparam int IDX_W  = mtfl_pkg::IDX_W;
	localparam int CNT_W  = mtfl_pkg::CNT_W;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_EXEC = 2'b10
	} fsm_t;

	fsm_t state_q;

	// Registered request.
	mtfl_pkg::cmd_t    cmd_q;
	logic [ITEM_W-1:0] item_q;
	logic [IDX_W-1:0]  idx_q;

	logic [CNT_W-1:0]  count_q;

	// Result register.
	logic              done_q;
	mtfl_pkg::stat_t   status_q;
	logic              found_q;
	logic [IDX_W-1:0]  pos_q;
	logic [ITEM_W-1:0] item_out_q;

	logic              accept;
	logic              exec;

	// Cell row.
	logic [ITEM_W-1:0]   cell_data [DEPTH];
	logic [DEPTH-1:0]    cell_match;
	mtfl_pkg::cell_ctl_t ctl;

	// Execute-cycle results.
	logic              any_match;
	logic [IDX_W-1:0]  first_pos;
	mtfl_pkg::stat_t   nxt_status;
	logic              nxt_found;
	logic [IDX_W-1:0]  nxt_pos;
	logic [CNT_W-1:0]  nxt_count;
	logic [ITEM_W-1:0] nxt_item;
	mtfl_pkg::cell_cmd_t nxt_ccmd;
	logic              full;
	logic              empty;

	assign accept = start && (state_q == FSM_IDLE);
	assign exec   = (state_q == FSM_EXEC);
	assign busy   = exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			case (state_q)
				FSM_IDLE: if (accept) state_q <= FSM_EXEC;
				FSM_EXEC: state_q <= FSM_IDLE;
				default:  state_q <= FSM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= mtfl_pkg::cmd_t'(command);
			item_q <= item_value;
			idx_q  <= index;
		end
	end

	// First match from the head; the cells only flag entries below the length.
	always_comb begin
		any_match = |cell_match;
		first_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i])
				first_pos = IDX_W'(i);
		end
	end

	always_comb begin
		full       = count_q >= CNT_W'(DEPTH);
		empty      = (count_q == '0);
		nxt_status = mtfl_pkg::STAT_OK;
		nxt_found  = 1'b0;
		nxt_pos    = '0;
		nxt_count  = count_q;
		nxt_item   = '0;
		nxt_ccmd   = mtfl_pkg::CC_NONE;
		case (cmd_q)
			mtfl_pkg::CMD_INS_HEAD, mtfl_pkg::CMD_APPEND: begin
				if (full) begin
					nxt_status = mtfl_pkg::STAT_FULL;
				end else begin
					nxt_ccmd  = (cmd_q == mtfl_pkg::CMD_INS_HEAD) ?
						mtfl_pkg::CC_PUSH : mtfl_pkg::CC_APPEND;
					nxt_count = count_q + CNT_W'(1);
				end
			end
			mtfl_pkg::CMD_DELETE, mtfl_pkg::CMD_TO_FRONT: begin
				if (empty) begin
					nxt_status = mtfl_pkg::STAT_EMPTY;
				end else if (!any_match) begin
					nxt_status = mtfl_pkg::STAT_NOTFOUND;
				end else begin
					nxt_found = 1'b1;
					nxt_pos   = first_pos;
					if (cmd_q == mtfl_pkg::CMD_DELETE) begin
						nxt_ccmd  = mtfl_pkg::CC_REMOVE;
						nxt_count = count_q - CNT_W'(1);
					end else begin
						nxt_ccmd  = mtfl_pkg::CC_TO_FRONT;
					end
				end
			end
			mtfl_pkg::CMD_CLEAR: begin
				if (empty)
					nxt_status = mtfl_pkg::STAT_EMPTY;
				nxt_count = '0;
			end
			mtfl_pkg::CMD_LOOKUP: begin
				if (any_match) begin
					nxt_found = 1'b1;
					nxt_pos   = first_pos;
				end else begin
					nxt_status = mtfl_pkg::STAT_NOTFOUND;
				end
			end
			mtfl_pkg::CMD_READ: begin
				if ({1'b0, idx_q} >= count_q)
					nxt_status = mtfl_pkg::STAT_RANGE;
				else
					nxt_item = cell_data[idx_q];
			end
			default: begin
				// undefined code: no-op, status ok
			end
		endcase
	end

	// Broadcast to the row; cells move only on the execute edge.
	assign ctl.cmd   = exec ? nxt_ccmd : mtfl_pkg::CC_NONE;
	assign ctl.pos   = first_pos;
	assign ctl.count = count_q;
	assign ctl.item  = item_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [ITEM_W-1:0] left_d;
		logic [ITEM_W-1:0] right_d;

		if (g == 0) begin : g_head
			assign left_d = item_q;
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end

		mtfl_cell u_cell (
			.clk        (clk),
			.cell_idx   (IDX_W'(g)),
			.ctl        (ctl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec)
				count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= nxt_status;
			found_q    <= nxt_found;
			pos_q      <= nxt_pos;
			item_out_q <= nxt_item;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign position    = pos_q;
	assign list_length = count_q;
	assign item_out    = item_out_q;

`ifndef SYNTHESIS
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding execute cycle");

	a_len_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> (count_q == $past(count_q)))
		else $error("list length changed outside execute");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == mtfl_pkg::STAT_FULL)) |-> (list_length == CNT_W'(DEPTH)))
		else $error("full status with list not at capacity");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (count_q <= CNT_W'(DEPTH)))
		else $error("list length beyond capacity");
`endif

endmodule

>>> tb/tb_move_to_front_ordered_list.sv
// Self-checking testbench for the move-to-front ordered list: directed and random requests.
module tb_move_to_front_ordered_list;
	timeunit 1ns;
	timeprecision 1ps;

	import mtfl_pkg::*;

	// Code 7 has no meaning: the block does nothing and reports ok.
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	localparam int N_RANDOM = 1350;
	localparam int POOL_N   = 6;

	// One pending request as the driver puts it on the ports.
	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] value;
		logic [3:0]  idx;
		bit          drain_first;  // hold off until every result is back
		int unsigned idle_pct;     // chance of an idle cycle before this request
	} request_t;

	// One result as the block should show it with done.
	typedef struct {
		stat_t             status;
		logic              found;
		logic [IDX_W-1:0]  position;
		logic [CNT_W-1:0]  list_length;
		logic [ITEM_W-1:0] item_out;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  command = CMD_CLEAR;
	logic [31:0] item_value = '0;
	logic [3:0]  index = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic        found;
	logic [3:0]  position;
	logic [4:0]  list_length;
	logic [31:0] item_out;

	request_t     pending_requests[$];
	list_result_t expected_results[$];

	// Shadow copy of the list, advanced once per accepted request.
	logic [ITEM_W-1:0] shadow_entries[DEPTH];
	int                shadow_len = 0;

	int error_count = 0;
	int n_accepted  = 0;
	int n_checked   = 0;
	int n_full      = 0;
	int n_moved     = 0;
	int n_cleared   = 0;

	move_to_front_ordered_list uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.item_value (item_value),
		.index      (index),
		.done       (done),
		.status     (status),
		.found      (found),
		.position   (position),
		.list_length(list_length),
		.item_out   (item_out)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		$display("%0t MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	task automatic queue_request(logic [2:0] cmd, logic [31:0] value, logic [3:0] idx,
			bit drain_first, int unsigned idle_pct);
		request_t r;
		r.cmd         = cmd;
		r.value       = value;
		r.idx         = idx;
		r.drain_first = drain_first;
		r.idle_pct    = idle_pct;
		pending_requests.push_back(r);
	endtask

	// Applies one request to the shadow list and returns the result it should give.
	function automatic list_result_t predict_request(logic [2:0] cmd, logic [31:0] value,
			logic [3:0] idx);
		list_result_t res;
		int           hit;
		int           i;
		res.status   = STAT_OK;
		res.found    = 1'b0;
		res.position = '0;
		res.item_out = '0;
		// First match counted from the head; -1 when there is none.
		hit = -1;
		for (i = 0; i < shadow_len; i++) begin
			if (hit < 0 && shadow_entries[i] == value)
				hit = i;
		end
		case (cmd)
			CMD_INS_HEAD, CMD_APPEND: begin
				if (shadow_len >= DEPTH) begin
					res.status = STAT_FULL;
					n_full++;
				end else if (cmd == CMD_INS_HEAD) begin
					for (i = shadow_len; i > 0; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[0] = value;
					shadow_len++;
				end else begin
					shadow_entries[shadow_len] = value;
					shadow_len++;
				end
			end
			CMD_DELETE, CMD_TO_FRONT: begin
				if (shadow_len == 0) begin
					res.status = STAT_EMPTY;
				end else if (hit < 0) begin
					res.status = STAT_NOTFOUND;
				end else begin
					res.found    = 1'b1;
					res.position = hit[IDX_W-1:0];
					if (cmd == CMD_DELETE) begin
						for (i = hit; i + 1 < shadow_len; i++)
							shadow_entries[i] = shadow_entries[i+1];
						shadow_len--;
					end else begin
						// Others keep their order, the match goes to the head.
						for (i = hit; i > 0; i--)
							shadow_entries[i] = shadow_entries[i-1];
						shadow_entries[0] = value;
						if (hit > 0)
							n_moved++;
					end
				end
			end
			CMD_CLEAR: begin
				if (shadow_len == 0)
					res.status = STAT_EMPTY;
				else
					n_cleared++;
				shadow_len = 0;
			end
			CMD_LOOKUP: begin
				if (hit < 0) begin
					res.status = STAT_NOTFOUND;
				end else begin
					res.found    = 1'b1;
					res.position = hit[IDX_W-1:0];
				end
			end
			CMD_READ: begin
				if (int'(idx) >= shadow_len)
					res.status = STAT_RANGE;
				else
					res.item_out = shadow_entries[idx];
			end
			default: ;
		endcase
		res.list_length = shadow_len[CNT_W-1:0];
		return res;
	endfunction

	// Driver: a request is taken at an edge with start high and busy low.
	// Every port gets at most one nonblocking write per edge.
	always @(posedge clk) begin
		bit launch;
		bit hold;
		launch = 1'b0;
		hold   = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_request(command, item_value, index));
				void'(pending_requests.pop_front());
				n_accepted++;
			end
			if (start && busy) begin
				// Not taken yet: keep the same request on the ports.
				hold = 1'b1;
			end else if (pending_requests.size() != 0) begin
				if (pending_requests[0].drain_first) begin
					// Quiet list: nothing owed, no result on the ports, not busy.
					// Checking done keeps this free of the monitor's pop order.
					launch = (expected_results.size() == 0) && !done && !busy;
				end else begin
					launch = ($urandom_range(99) >= pending_requests[0].idle_pct);
				end
			end
			if (!hold) begin
				if (launch) begin
					start      <= 1'b1;
					command    <= pending_requests[0].cmd;
					item_value <= pending_requests[0].value;
					index      <= pending_requests[0].idx;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done marks a result for exactly one cycle; compare to the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request outstanding", {29'd0, status}, 0);
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (status !== want.status)
					report_mismatch("status", {29'd0, status}, {29'd0, want.status});
				if (found !== want.found)
					report_mismatch("found", {31'd0, found}, {31'd0, want.found});
				if (position !== want.position)
					report_mismatch("position", {28'd0, position}, {28'd0, want.position});
				if (list_length !== want.list_length)
					report_mismatch("list_length", {27'd0, list_length},
						{27'd0, want.list_length});
				if (item_out !== want.item_out)
					report_mismatch("item_out", item_out, want.item_out);
			end
		end
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("tb_move_to_front_ordered_list: errors");
		$finish;
	end

	initial begin
		logic [31:0] value_pool[POOL_N];
		logic [2:0]  cmd_codes[8];
		int          cuts[3][8];
		int          mode;
		int          phase;
		int          r;
		int          k;
		int          n;
		logic [2:0]  cmd;
		logic [31:0] value;
		bit          drain;
		int unsigned idle_pcts[3];

		cmd_codes = '{CMD_INS_HEAD, CMD_APPEND, CMD_DELETE, CMD_TO_FRONT,
			CMD_CLEAR, CMD_LOOKUP, CMD_READ, CMD_UNUSED};
		// Cumulative weights per mode: growing, shrinking, balanced.
		cuts[0] = '{25, 50, 58, 70, 71, 83, 99, 100};
		cuts[1] = '{10, 18, 53, 65, 69, 81, 99, 100};
		cuts[2] = '{18, 34, 52, 66, 68, 82, 99, 100};
		// Sender idle rate by phase; the last phase runs back to back.
		idle_pcts = '{28, 67, 0};

		// Directed part: empty-list cases, extremes, duplicates, every command.
		queue_request(CMD_CLEAR,    32'h0000_0000, 4'd0,  1'b0, 28); // clear when empty
		queue_request(CMD_DELETE,   32'h0000_0000, 4'd0,  1'b0, 28); // delete on empty
		queue_request(CMD_TO_FRONT, 32'hFFFF_FFFF, 4'd15, 1'b0, 28); // move on empty
		queue_request(CMD_LOOKUP,   32'h0000_0000, 4'd0,  1'b0, 28); // lookup on empty
		queue_request(CMD_READ,     32'h0000_0000, 4'd0,  1'b0, 28); // read past length
		queue_request(CMD_UNUSED,   32'hFFFF_FFFF, 4'd15, 1'b0, 28); // meaningless code
		queue_request(CMD_INS_HEAD, 32'h0000_0000, 4'd0,  1'b0, 28);
		queue_request(CMD_APPEND,   32'hFFFF_FFFF, 4'd0,  1'b0, 28);
		queue_request(CMD_INS_HEAD, 32'hA5A5_5A5A, 4'd0,  1'b0, 28);
		queue_request(CMD_APPEND,   32'h0000_0000, 4'd0,  1'b0, 28); // duplicate
		queue_request(CMD_LOOKUP,   32'h0000_0000, 4'd0,  1'b0, 28); // first of two
		queue_request(CMD_LOOKUP,   32'hFFFF_FFFF, 4'd0,  1'b0, 28);
		queue_request(CMD_LOOKUP,   32'h1234_5678, 4'd0,  1'b0, 28); // no match
		queue_request(CMD_TO_FRONT, 32'hFFFF_FFFF, 4'd0,  1'b0, 28);
		queue_request(CMD_TO_FRONT, 32'hFFFF_FFFF, 4'd0,  1'b0, 28); // already at head
		queue_request(CMD_DELETE,   32'h1234_5678, 4'd0,  1'b0, 28); // no match
		queue_request(CMD_TO_FRONT, 32'h1234_5678, 4'd0,  1'b0, 28); // no match
		queue_request(CMD_DELETE,   32'h0000_0000, 4'd0,  1'b0, 28); // first of two
		queue_request(CMD_READ,     32'h0000_0000, 4'd0,  1'b0, 28);
		queue_request(CMD_READ,     32'h0000_0000, 4'd2,  1'b0, 28);
		queue_request(CMD_READ,     32'h0000_0000, 4'd3,  1'b0, 28); // just past end
		queue_request(CMD_READ,     32'h0000_0000, 4'd15, 1'b0, 28);
		queue_request(CMD_CLEAR,    32'h0000_0000, 4'd0,  1'b0, 28);

		// Random part: values mostly from a small pool so matches and duplicates are
		// common; the mode is drawn anew every 40 requests so the list fills and drains.
		for (k = 0; k < POOL_N; k++)
			value_pool[k] = $urandom;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		mode = 0;
		for (n = 0; n < N_RANDOM; n++) begin
			if (n % 40 == 0)
				mode = (n == 0) ? 0 : $urandom_range(2);
			if ($urandom_range(99) < 5)
				value_pool[$urandom_range(POOL_N-1)] = $urandom;
			phase = (n * 3) / N_RANDOM;
			r = $urandom_range(99);
			cmd = CMD_UNUSED;
			for (k = 7; k >= 0; k--) begin
				if (r < cuts[mode][k])
					cmd = cmd_codes[k];
			end
			value = ($urandom_range(99) < 85) ? value_pool[$urandom_range(POOL_N-1)]
				: $urandom;
			// Drain at each phase start and now and then at random.
			drain = (n == 0) || (n == N_RANDOM / 3) || (n == (2 * N_RANDOM) / 3)
				|| ($urandom_range(99) == 0);
			queue_request(cmd, value, 4'($urandom_range(15)), drain, idle_pcts[phase]);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		// Then wait on, to catch a stray done.
		repeat (6) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never arrived", expected_results.size(), 0);

		$display("%0d requests, %0d results checked under three pacing phases",
			n_accepted, n_checked);
		$display("full refusals %0d, moves from behind the head %0d, clears of a filled list %0d",
			n_full, n_moved, n_cleared);
		if (error_count == 0) begin
			$display("tb_move_to_front_ordered_list: clean");
		end else begin
			$display("tb_move_to_front_ordered_list: errors");
		end
		$finish;
	end

endmodule
